// File: sv/modular_square_root_assert.svh
// assertion macros for the rtl
`ifndef MODULAR_SQUARE_ROOT_ASSERT_SVH
`define MODULAR_SQUARE_ROOT_ASSERT_SVH

// condition implies consequence in the same cycle
`define MSR_ASSERT_SAME(label, clk, rst_n, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error(msg);

// condition implies consequence in the next cycle
`define MSR_ASSERT_NEXT(label, clk, rst_n, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/msr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package msr_pkg;

    localparam int MOD_BITS     = 32;
    localparam int VAL_BITS     = 64;
    localparam int SEARCH_LIMIT = 1024;
    localparam int CNT_BITS     = $clog2(SEARCH_LIMIT + 1);
    localparam int STEP_BITS    = $clog2(VAL_BITS + 1);
    localparam int IDX_BITS     = 5;

    // positions in the extension field sequence table
    localparam logic [IDX_BITS-1:0] CI_INIT_LAST = 5'd4;
    localparam logic [IDX_BITS-1:0] CI_MUL_FIRST = 5'd5;
    localparam logic [IDX_BITS-1:0] CI_SQ_FIRST  = 5'd13;
    localparam logic [IDX_BITS-1:0] CI_LAST      = 5'd19;

    typedef logic [MOD_BITS-1:0] mword_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_REDUCE,
        OP_MUL,
        OP_ADD,
        OP_SUB,
        OP_LOAD_HALF,
        OP_LOAD_UP,
        OP_SHIFT_E,
        OP_RESULT
    } msr_op_t;

    typedef enum logic [3:0] {
        R_ZERO,
        R_ONE,
        R_A,
        R_D,
        R_BM,
        R_ACC,
        R_SQ,
        R_RR,
        R_RI,
        R_TR,
        R_TI,
        R_T1,
        R_T2,
        R_T3
    } msr_reg_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_NONRES = 2'd1,
        ST_LIMIT  = 2'd2
    } msr_status_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_CHECK,
        S_REDUCE,
        S_SPECIAL,
        S_EU_I0,
        S_EU_I1,
        S_EU_I2,
        S_EU_TEST,
        S_EU_MUL,
        S_EU_SQ,
        S_EU_SHIFT,
        S_EU_END,
        S_SR_INIT,
        S_SR_D1,
        S_SR_D2,
        S_SR_NEXT,
        S_CI_INIT,
        S_CI_TEST,
        S_CI_RUN,
        S_CI_SHIFT,
        S_DONE
    } msr_state_t;

    typedef struct packed {
        msr_op_t     op;
        msr_reg_t    src_a;
        msr_reg_t    src_b;
        msr_reg_t    dst;
        msr_status_t st;
    } msr_cmd_t;

    typedef struct packed {
        logic busy;
        logic done;
        logic e_zero;
        logic e_lsb;
        logic acc_one;
        logic acc_pm1;
        logic p_zero;
        logic p_one;
        logic p_two;
        logic a_zero;
        logic out_free;
    } msr_stat_t;

    function automatic msr_cmd_t make_cmd(msr_op_t op, msr_reg_t a, msr_reg_t b,
                                          msr_reg_t d);
        msr_cmd_t c;
        c.op    = op;
        c.src_a = a;
        c.src_b = b;
        c.dst   = d;
        c.st    = ST_OK;
        return c;
    endfunction

    function automatic logic is_multi(msr_op_t op);
        return (op == OP_MUL) || (op == OP_REDUCE);
    endfunction

    // extension field steps: setup, multiply into result, square the base
    function automatic msr_cmd_t ci_cmd(logic [IDX_BITS-1:0] idx);
        msr_cmd_t c;
        c = make_cmd(OP_NONE, R_ZERO, R_ZERO, R_ZERO);
        case (idx)
            5'd0:    c = make_cmd(OP_ADD, R_BM, R_ZERO, R_TR);
            5'd1:    c = make_cmd(OP_ADD, R_ONE, R_ZERO, R_TI);
            5'd2:    c = make_cmd(OP_ADD, R_ONE, R_ZERO, R_RR);
            5'd3:    c = make_cmd(OP_ADD, R_ZERO, R_ZERO, R_RI);
            5'd4:    c = make_cmd(OP_LOAD_UP, R_ZERO, R_ZERO, R_ZERO);
            5'd5:    c = make_cmd(OP_MUL, R_RR, R_TR, R_T1);
            5'd6:    c = make_cmd(OP_MUL, R_RI, R_TI, R_T2);
            5'd7:    c = make_cmd(OP_MUL, R_T2, R_D, R_T2);
            5'd8:    c = make_cmd(OP_ADD, R_T1, R_T2, R_T1);
            5'd9:    c = make_cmd(OP_MUL, R_RR, R_TI, R_T2);
            5'd10:   c = make_cmd(OP_MUL, R_RI, R_TR, R_T3);
            5'd11:   c = make_cmd(OP_ADD, R_T2, R_T3, R_RI);
            5'd12:   c = make_cmd(OP_ADD, R_T1, R_ZERO, R_RR);
            5'd13:   c = make_cmd(OP_MUL, R_TR, R_TR, R_T1);
            5'd14:   c = make_cmd(OP_MUL, R_TI, R_TI, R_T2);
            5'd15:   c = make_cmd(OP_MUL, R_T2, R_D, R_T2);
            5'd16:   c = make_cmd(OP_ADD, R_T1, R_T2, R_T1);
            5'd17:   c = make_cmd(OP_MUL, R_TR, R_TI, R_T2);
            5'd18:   c = make_cmd(OP_ADD, R_T2, R_T2, R_TI);
            5'd19:   c = make_cmd(OP_ADD, R_T1, R_ZERO, R_TR);
            default: c = make_cmd(OP_NONE, R_ZERO, R_ZERO, R_ZERO);
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

// File: sv/modular_square_root.sv
`timescale 1ns / 1ps
`default_nettype none

// channel   signals                      direction
// input     in_valid in_ready value modulus   into block
// output    out_valid out_ready root status   out of block
//
// one item at a time; each modular multiply and the signed reduction run on the
// single shared shift-add unit; the work is the euler test on the value, one
// euler test per search candidate and the extension field power
// rst_n clears the controller, the multiply unit and the output valid
// a finished result waits in the output register; input is taken again at once

module modular_square_root (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [63:0] value,
    input  logic [31:0] modulus,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] root,
    output logic [1:0]  status
);
    import msr_pkg::*;

    msr_cmd_t  cmd;
    logic      cmd_valid;
    msr_stat_t dp_stat;

    msr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .stat      (dp_stat),
        .cmd       (cmd),
        .cmd_valid (cmd_valid)
    );

    msr_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .cmd_valid (cmd_valid),
        .value     (value),
        .modulus   (modulus),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .root      (root),
        .status    (status),
        .stat      (dp_stat)
    );

`include "modular_square_root_assert.svh"

    // block is busy right after taking an item
    `MSR_ASSERT_NEXT(a_busy_after_in, clk, rst_n, in_valid && in_ready, !in_ready, "ready after accept")
    // the multiply unit never runs while the block waits for input
    `MSR_ASSERT_SAME(a_idle_unit, clk, rst_n, in_ready, !dp_stat.busy, "unit busy while idle")
    // a failed result carries a zero root
    `MSR_ASSERT_SAME(a_fail_zero, clk, rst_n, out_valid && (status != ST_OK), root == '0, "root on failure")

endmodule

`default_nettype wire

// File: sv/msr_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module msr_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  msr_pkg::msr_cmd_t   cmd,
    input  logic                cmd_valid,
    input  logic [63:0]         value,
    input  logic [31:0]         modulus,
    input  logic                out_ready,
    output logic                out_valid,
    output logic [31:0]         root,
    output logic [1:0]          status,
    output msr_pkg::msr_stat_t  stat
);
    import msr_pkg::*;

    localparam int W2 = MOD_BITS + 2;

    mword_t                p_reg;
    logic [VAL_BITS-1:0]   val_reg;
    mword_t                a_reg, d_reg, bm_reg, acc_reg, sq_reg;
    mword_t                rr_reg, ri_reg, tr_reg, ti_reg, t1_reg, t2_reg, t3_reg;
    mword_t                e_reg;

    logic                  mu_busy_reg;
    logic [STEP_BITS-1:0]  mu_cnt_reg;
    mword_t                mu_acc_reg, mu_x_reg;
    logic [VAL_BITS-1:0]   mu_y_reg;
    msr_reg_t              mu_dst_reg;
    logic                  mu_neg_reg, mu_red_reg;

    logic                  out_valid_reg;
    mword_t                root_reg;
    msr_status_t           status_reg;

    mword_t                op_a, op_b;
    mword_t                add_res, sub_res, mu_step, mu_final;
    logic                  mu_done;
    logic [W2-1:0]         mu_t, p_ext, p_dbl;
    logic [MOD_BITS:0]     add_sum, sub_dif;
    logic                  wr_en;
    msr_reg_t              wr_dst;
    mword_t                wr_data;
    logic                  start_mul, start_red;

    // operand read selection
    always_comb
    begin
        case (cmd.src_a)
            R_ONE:   op_a = MOD_BITS'(1);
            R_A:     op_a = a_reg;
            R_D:     op_a = d_reg;
            R_BM:    op_a = bm_reg;
            R_ACC:   op_a = acc_reg;
            R_SQ:    op_a = sq_reg;
            R_RR:    op_a = rr_reg;
            R_RI:    op_a = ri_reg;
            R_TR:    op_a = tr_reg;
            R_TI:    op_a = ti_reg;
            R_T1:    op_a = t1_reg;
            R_T2:    op_a = t2_reg;
            R_T3:    op_a = t3_reg;
            default: op_a = '0;
        endcase
        case (cmd.src_b)
            R_ONE:   op_b = MOD_BITS'(1);
            R_A:     op_b = a_reg;
            R_D:     op_b = d_reg;
            R_BM:    op_b = bm_reg;
            R_ACC:   op_b = acc_reg;
            R_SQ:    op_b = sq_reg;
            R_RR:    op_b = rr_reg;
            R_RI:    op_b = ri_reg;
            R_TR:    op_b = tr_reg;
            R_TI:    op_b = ti_reg;
            R_T1:    op_b = t1_reg;
            R_T2:    op_b = t2_reg;
            R_T3:    op_b = t3_reg;
            default: op_b = '0;
        endcase
    end

    // modular add and subtract, operands already below p
    always_comb
    begin
        add_sum = {1'b0, op_a} + {1'b0, op_b};
        if (add_sum >= {1'b0, p_reg})
            add_res = MOD_BITS'(add_sum - {1'b0, p_reg});
        else
            add_res = add_sum[MOD_BITS-1:0];
        sub_dif = {1'b0, op_a} - {1'b0, op_b};
        if (op_a < op_b)
            sub_res = MOD_BITS'(sub_dif + {1'b0, p_reg});
        else
            sub_res = sub_dif[MOD_BITS-1:0];
    end

    // one bit per cycle of shift-add modular multiply or reduction
    always_comb
    begin
        p_ext = {2'b00, p_reg};
        p_dbl = {1'b0, p_reg, 1'b0};
        mu_t  = {1'b0, mu_acc_reg, 1'b0} + (mu_y_reg[VAL_BITS-1] ? {2'b00, mu_x_reg} : '0);
        if (mu_t >= p_dbl)
            mu_step = MOD_BITS'(mu_t - p_dbl);
        else if (mu_t >= p_ext)
            mu_step = MOD_BITS'(mu_t - p_ext);
        else
            mu_step = mu_t[MOD_BITS-1:0];
        mu_done = mu_busy_reg && (mu_cnt_reg == STEP_BITS'(1));
        if (mu_red_reg && mu_neg_reg)
            mu_final = p_reg - MOD_BITS'(1) - mu_step;
        else
            mu_final = mu_step;
    end

    assign start_mul = cmd_valid && (cmd.op == OP_MUL);
    assign start_red = cmd_valid && (cmd.op == OP_REDUCE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mu_busy_reg <= 1'b0;
        end
        else if (start_mul || start_red)
        begin
            mu_busy_reg <= 1'b1;
        end
        else if (mu_done)
        begin
            mu_busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start_mul)
        begin
            mu_cnt_reg <= STEP_BITS'(MOD_BITS);
            mu_acc_reg <= '0;
            mu_x_reg   <= op_a;
            mu_y_reg   <= {op_b, {(VAL_BITS-MOD_BITS){1'b0}}};
            mu_dst_reg <= cmd.dst;
            mu_red_reg <= 1'b0;
            mu_neg_reg <= 1'b0;
        end
        else if (start_red)
        begin
            mu_cnt_reg <= STEP_BITS'(VAL_BITS);
            mu_acc_reg <= '0;
            mu_x_reg   <= MOD_BITS'(1);
            mu_y_reg   <= val_reg[VAL_BITS-1] ? ~val_reg : val_reg;
            mu_dst_reg <= cmd.dst;
            mu_red_reg <= 1'b1;
            mu_neg_reg <= val_reg[VAL_BITS-1];
        end
        else if (mu_busy_reg)
        begin
            mu_cnt_reg <= mu_cnt_reg - STEP_BITS'(1);
            mu_acc_reg <= mu_step;
            mu_y_reg   <= {mu_y_reg[VAL_BITS-2:0], 1'b0};
        end
    end

    // register file write back
    always_comb
    begin
        wr_en   = 1'b0;
        wr_dst  = cmd.dst;
        wr_data = add_res;
        if (mu_done)
        begin
            wr_en   = 1'b1;
            wr_dst  = mu_dst_reg;
            wr_data = mu_final;
        end
        else if (cmd_valid && (cmd.op == OP_ADD))
        begin
            wr_en   = 1'b1;
        end
        else if (cmd_valid && (cmd.op == OP_SUB))
        begin
            wr_en   = 1'b1;
            wr_data = sub_res;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            case (wr_dst)
                R_A:     a_reg   <= wr_data;
                R_D:     d_reg   <= wr_data;
                R_BM:    bm_reg  <= wr_data;
                R_ACC:   acc_reg <= wr_data;
                R_SQ:    sq_reg  <= wr_data;
                R_RR:    rr_reg  <= wr_data;
                R_RI:    ri_reg  <= wr_data;
                R_TR:    tr_reg  <= wr_data;
                R_TI:    ti_reg  <= wr_data;
                R_T1:    t1_reg  <= wr_data;
                R_T2:    t2_reg  <= wr_data;
                R_T3:    t3_reg  <= wr_data;
                default: ;
            endcase
        end
    end

    // operand capture and exponent register
    always_ff @(posedge clk)
    begin
        if (cmd_valid)
        begin
            case (cmd.op)
                OP_LOAD:
                begin
                    p_reg   <= modulus[MOD_BITS-1:0];
                    val_reg <= value;
                end
                OP_LOAD_HALF: e_reg <= (p_reg - MOD_BITS'(1)) >> 1;
                OP_LOAD_UP:   e_reg <= MOD_BITS'(({1'b0, p_reg} + (MOD_BITS+1)'(1)) >> 1);
                OP_SHIFT_E:   e_reg <= e_reg >> 1;
                default: ;
            endcase
        end
    end

    // output register, freed by a transfer on the result side
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd_valid && (cmd.op == OP_RESULT))
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_valid && (cmd.op == OP_RESULT))
        begin
            root_reg   <= op_a;
            status_reg <= cmd.st;
        end
    end

    assign out_valid = out_valid_reg;
    assign root      = 32'(root_reg);
    assign status    = status_reg;

    always_comb
    begin
        stat.busy     = mu_busy_reg;
        stat.done     = mu_done;
        stat.e_zero   = (e_reg == '0);
        stat.e_lsb    = e_reg[0];
        stat.acc_one  = (acc_reg == MOD_BITS'(1));
        stat.acc_pm1  = (acc_reg == (p_reg - MOD_BITS'(1)));
        stat.p_zero   = (p_reg == '0);
        stat.p_one    = (p_reg == MOD_BITS'(1));
        stat.p_two    = (p_reg == MOD_BITS'(2));
        stat.a_zero   = (a_reg == '0);
        stat.out_free = !out_valid_reg || out_ready;
    end

endmodule

`default_nettype wire

// File: sv/msr_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module msr_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  msr_pkg::msr_stat_t  stat,
    output msr_pkg::msr_cmd_t   cmd,
    output logic                cmd_valid
);
    import msr_pkg::*;

    msr_state_t            state_reg, state_next;
    logic                  issued_reg, issued_next;
    logic [IDX_BITS-1:0]   idx_reg, idx_next;
    logic [CNT_BITS-1:0]   bcnt_reg, bcnt_next;
    msr_reg_t              base_reg, base_next;
    logic                  search_reg, search_next;
    msr_reg_t              res_src_reg, res_src_next;
    msr_status_t           res_st_reg, res_st_next;
    logic                  adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            issued_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            issued_reg <= issued_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg     <= idx_next;
        bcnt_reg    <= bcnt_next;
        base_reg    <= base_next;
        search_reg  <= search_next;
        res_src_reg <= res_src_next;
        res_st_reg  <= res_st_next;
    end

    always_comb
    begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        bcnt_next    = bcnt_reg;
        base_next    = base_reg;
        search_next  = search_reg;
        res_src_next = res_src_reg;
        res_st_next  = res_st_reg;
        in_ready     = 1'b0;
        cmd          = make_cmd(OP_NONE, R_ZERO, R_ZERO, R_ZERO);

        // command for the current step
        unique case (state_reg)
            S_IDLE:     cmd = make_cmd(OP_LOAD, R_ZERO, R_ZERO, R_ZERO);
            S_REDUCE:   cmd = make_cmd(OP_REDUCE, R_ZERO, R_ZERO, R_A);
            S_EU_I0:    cmd = make_cmd(OP_ADD, base_reg, R_ZERO, R_SQ);
            S_EU_I1:    cmd = make_cmd(OP_ADD, R_ONE, R_ZERO, R_ACC);
            S_EU_I2:    cmd = make_cmd(OP_LOAD_HALF, R_ZERO, R_ZERO, R_ZERO);
            S_EU_MUL:   cmd = make_cmd(OP_MUL, R_ACC, R_SQ, R_ACC);
            S_EU_SQ:    cmd = make_cmd(OP_MUL, R_SQ, R_SQ, R_SQ);
            S_EU_SHIFT: cmd = make_cmd(OP_SHIFT_E, R_ZERO, R_ZERO, R_ZERO);
            S_SR_INIT:  cmd = make_cmd(OP_ADD, R_ONE, R_ZERO, R_BM);
            S_SR_D1:    cmd = make_cmd(OP_MUL, R_BM, R_BM, R_D);
            S_SR_D2:    cmd = make_cmd(OP_SUB, R_D, R_A, R_D);
            S_SR_NEXT:  cmd = make_cmd(OP_ADD, R_BM, R_ONE, R_BM);
            S_CI_INIT:  cmd = ci_cmd(idx_reg);
            S_CI_RUN:   cmd = ci_cmd(idx_reg);
            S_CI_SHIFT: cmd = make_cmd(OP_SHIFT_E, R_ZERO, R_ZERO, R_ZERO);
            S_DONE:
            begin
                cmd    = make_cmd(OP_RESULT, res_src_reg, R_ZERO, R_ZERO);
                cmd.st = res_st_reg;
            end
            default:    cmd = make_cmd(OP_NONE, R_ZERO, R_ZERO, R_ZERO);
        endcase

        // multi-cycle ops issue once and wait for done
        if (is_multi(cmd.op))
        begin
            cmd_valid   = !issued_reg;
            adv         = stat.done;
            issued_next = !stat.done;
        end
        else
        begin
            cmd_valid   = (cmd.op != OP_NONE);
            adv         = 1'b1;
            issued_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                in_ready  = 1'b1;
                cmd_valid = in_valid;
                if (in_valid)
                    state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (stat.p_zero)
                begin
                    res_src_next = R_ZERO;
                    res_st_next  = ST_NONRES;
                    state_next   = S_DONE;
                end
                else if (stat.p_one)
                begin
                    res_src_next = R_ZERO;
                    res_st_next  = ST_OK;
                    state_next   = S_DONE;
                end
                else
                    state_next = S_REDUCE;
            end
            S_REDUCE:
            begin
                if (adv)
                    state_next = S_SPECIAL;
            end
            S_SPECIAL:
            begin
                res_st_next = ST_OK;
                if (stat.p_two)
                begin
                    res_src_next = R_A;
                    state_next   = S_DONE;
                end
                else if (stat.a_zero)
                begin
                    res_src_next = R_ZERO;
                    state_next   = S_DONE;
                end
                else
                begin
                    base_next   = R_A;
                    search_next = 1'b0;
                    state_next  = S_EU_I0;
                end
            end
            S_EU_I0:    state_next = S_EU_I1;
            S_EU_I1:    state_next = S_EU_I2;
            S_EU_I2:    state_next = S_EU_TEST;
            S_EU_TEST:
            begin
                if (stat.e_zero)
                    state_next = S_EU_END;
                else if (stat.e_lsb)
                    state_next = S_EU_MUL;
                else
                    state_next = S_EU_SQ;
            end
            S_EU_MUL:
            begin
                if (adv)
                    state_next = S_EU_SQ;
            end
            S_EU_SQ:
            begin
                if (adv)
                    state_next = S_EU_SHIFT;
            end
            S_EU_SHIFT: state_next = S_EU_TEST;
            S_EU_END:
            begin
                res_src_next = R_ZERO;
                if (!search_reg)
                begin
                    if (!stat.acc_one)
                    begin
                        res_st_next = ST_NONRES;
                        state_next  = S_DONE;
                    end
                    else
                        state_next = S_SR_INIT;
                end
                else if (stat.acc_pm1)
                begin
                    idx_next   = '0;
                    state_next = S_CI_INIT;
                end
                else if (bcnt_reg == CNT_BITS'(SEARCH_LIMIT))
                begin
                    res_st_next = ST_LIMIT;
                    state_next  = S_DONE;
                end
                else
                    state_next = S_SR_NEXT;
            end
            S_SR_INIT:
            begin
                bcnt_next  = CNT_BITS'(1);
                state_next = S_SR_D1;
            end
            S_SR_D1:
            begin
                if (adv)
                    state_next = S_SR_D2;
            end
            S_SR_D2:
            begin
                base_next   = R_D;
                search_next = 1'b1;
                state_next  = S_EU_I0;
            end
            S_SR_NEXT:
            begin
                bcnt_next  = bcnt_reg + CNT_BITS'(1);
                state_next = S_SR_D1;
            end
            S_CI_INIT:
            begin
                if (idx_reg == CI_INIT_LAST)
                    state_next = S_CI_TEST;
                else
                    idx_next = idx_reg + IDX_BITS'(1);
            end
            S_CI_TEST:
            begin
                if (stat.e_zero)
                begin
                    res_src_next = R_RR;
                    res_st_next  = ST_OK;
                    state_next   = S_DONE;
                end
                else if (stat.e_lsb)
                begin
                    idx_next   = CI_MUL_FIRST;
                    state_next = S_CI_RUN;
                end
                else
                begin
                    idx_next   = CI_SQ_FIRST;
                    state_next = S_CI_RUN;
                end
            end
            S_CI_RUN:
            begin
                if (adv)
                begin
                    if (idx_reg == CI_LAST)
                        state_next = S_CI_SHIFT;
                    else
                        idx_next = idx_reg + IDX_BITS'(1);
                end
            end
            S_CI_SHIFT: state_next = S_CI_TEST;
            S_DONE:
            begin
                cmd_valid = stat.out_free;
                if (stat.out_free)
                    state_next = S_IDLE;
            end
            default:    state_next = S_IDLE;
        endcase
    end

endmodule

`default_nettype wire
